@@ hdl/assert_macros.svh @@
// Assertion macros shared by the smoothing filter RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define MASF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define MASF_ASSERT_IMPL(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error(msg);

`endif

@@ hdl/masf_pkg.sv @@
// Shared constants, types and register indexes of the smoothing filter.
// No dependencies.
`default_nettype none

package masf_pkg;

  // Fixed field widths
  localparam int CH_FIELD_W = 2;
  localparam int SAMPLE_W   = 12;
  localparam int SMOOTH_W   = 12;
  localparam int MV_W       = 14;
  localparam int MV_MAX     = 16383;
  localparam int RATE_W     = 9;
  localparam int MVLSB_W    = 18;
  localparam int RATE_CH    = 4;
  localparam int RATE_ONE   = 256;
  localparam int MV_SHIFT   = 16;

  // Parameter defaults
  localparam int CHANNELS_DEF    = 4;
  localparam int DEPTH_DEF       = 4;
  localparam int SAMPLE_BITS_DEF = 12;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = MVLSB_W;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_CH0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_CH1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_CH2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_CH3    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MV_PER_LSB  = 3'd5;

  localparam logic                 MODE_MEAN    = 1'b0;
  localparam logic                 MODE_LOWPASS = 1'b1;

  localparam logic [RATE_W-1:0]  RATE0_RST = 9'd51;
  localparam logic [RATE_W-1:0]  RATE_RST  = 9'd26;
  localparam logic [MVLSB_W-1:0] MVLSB_RST = 18'd52813;

  // Register file contents seen by the datapath
  typedef struct packed {
    logic                             mode;
    logic [RATE_CH-1:0][RATE_W-1:0]   rate;
    logic [MVLSB_W-1:0]               mv_per_lsb;
  } cfg_t;

  // Sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_STEP1 = 7'b0000010,
    S_STEP2 = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_MERGE = 7'b0010000,
    S_SCALE = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

@@ hdl/masf_if.sv @@
// Request channels of the smoothing filter: sample in, result out.
// Depends on masf_pkg.
`default_nettype none

interface masf_in_if import masf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CH_FIELD_W-1:0] channel;
  logic [SAMPLE_W-1:0]   sample;

  modport source (output valid, channel, sample, input ready);
  modport sink   (input valid, channel, sample, output ready);
endinterface

interface masf_out_if import masf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CH_FIELD_W-1:0] out_channel;
  logic [SMOOTH_W-1:0]   smoothed;
  logic [MV_W-1:0]       millivolts;
  logic                  changed;

  modport source (output valid, out_channel, smoothed, millivolts, changed, input ready);
  modport sink   (input valid, out_channel, smoothed, millivolts, changed, output ready);
endinterface

`default_nettype wire

@@ hdl/multichannel_adc_smoothing_filter_top.sv @@
// Top level of the per-channel smoothing filter: sequencer and datapath.
// Depends on masf_pkg, masf_if, masf_cfg_regs, masf_mul, masf_chan_store.
//
//   port      direction  contents
//   in_bus    sink       channel, sample
//   out_bus   source     out_channel, smoothed, millivolts, changed
//   cfg_*     input      write enable, register index, write data
//
// A sample steps through STEP1, STEP2, MERGE, SCALE and OUT in low-pass mode,
// STEP1, DIV, MERGE, SCALE and OUT when a mean block completes, and STEP1, SCALE
// and OUT when a block is still filling or the channel is not present; one
// multiplier is stepped through all products. rst_n clears channel state and
// the sequencer; registers return to their reset values. A full, unaccepted
// result holds the sequencer in OUT; the input is ready only when it is idle.
`default_nettype none

module multichannel_adc_smoothing_filter_top
  import masf_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int DEPTH       = DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  masf_in_if.sink                    in_bus,
  masf_out_if.source                 out_bus,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "assert_macros.svh"

  // Derived widths
  localparam int SMP_W   = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int LOG_D   = $clog2(DEPTH);
  localparam int SUM_W   = SMP_W + LOG_D;
  localparam int CNT_W   = (LOG_D > 0) ? LOG_D : 1;
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MUL_A_W = (SUM_W > SMOOTH_W) ? SUM_W : SMOOTH_W;
  localparam int MUL_B_W = (SUM_W + 1 > MVLSB_W) ? SUM_W + 1 : MVLSB_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = SMOOTH_W + RATE_W;
  localparam int MVF_W   = PROD_W - MV_SHIFT;
  // Exact reciprocal for the block mean: floor(x / DEPTH) = (x * DIV_M) >> DIV_K
  localparam int DIV_K   = SUM_W + LOG_D;
  localparam longint DIV_M_L = ((64'd1 << DIV_K) + DEPTH - 1) / DEPTH;
  localparam logic [MUL_B_W-1:0] DIV_M = MUL_B_W'(DIV_M_L);

  cfg_t cfg;

  state_t st_r, st_nxt;

  logic [CH_FIELD_W-1:0] ch_r;
  logic [SMP_W-1:0]      smp_r;
  logic [ACC_W-1:0]      acc_r;
  logic [SUM_W-1:0]      sum_r;
  logic [SMOOTH_W-1:0]   newv_r;
  logic                  chg_r;

  logic                  out_valid_r;
  logic [CH_FIELD_W-1:0] out_ch_r;
  logic [SMOOTH_W-1:0]   out_smooth_r;
  logic [MV_W-1:0]       out_mv_r;
  logic                  out_chg_r;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_r;

  logic [SMOOTH_W-1:0] smooth_rd;
  logic [SUM_W-1:0]    sum_rd;
  logic [CNT_W-1:0]    cnt_rd;
  logic                smooth_we;
  logic                blk_we;
  logic [SUM_W-1:0]    sum_wd;
  logic [CNT_W-1:0]    cnt_wd;

  logic                in_acc;
  logic                ch_ok;
  logic                blk_done;
  logic [RATE_W-1:0]   rate_raw;
  logic [RATE_W-1:0]   rate_sat;
  logic [RATE_W-1:0]   rate_inv;
  logic [SUM_W-1:0]    sum_acc;
  logic [ACC_W-1:0]    blend;
  logic [SMOOTH_W-1:0] merge_v;
  logic [MVF_W-1:0]    mv_full;
  logic [MV_W-1:0]     mv_sat;
  logic                out_load;

  masf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  masf_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  masf_chan_store #(
    .CHANNELS (CHANNELS),
    .CH_W     (CH_W),
    .SUM_W    (SUM_W),
    .CNT_W    (CNT_W)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .idx       (CH_W'(ch_r)),
    .smooth_rd (smooth_rd),
    .sum_rd    (sum_rd),
    .cnt_rd    (cnt_rd),
    .smooth_we (smooth_we),
    .smooth_wd (merge_v),
    .blk_we    (blk_we),
    .sum_wd    (sum_wd),
    .cnt_wd    (cnt_wd)
  );

  // Request handshake on the input side
  assign in_bus.ready = (st_r == S_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;

  // Channel checks and rate limiting
  assign ch_ok    = (int'(ch_r) < CHANNELS);
  assign rate_raw = cfg.rate[ch_r];
  assign rate_sat = (rate_raw[RATE_W-1] && (|rate_raw[RATE_W-2:0])) ?
                    RATE_W'(RATE_ONE) : rate_raw;
  assign rate_inv = RATE_W'(RATE_ONE) - rate_sat;

  // Block accumulation
  assign sum_acc  = sum_rd + SUM_W'(smp_r);
  assign blk_done = (cnt_rd == CNT_W'(DEPTH - 1));

  // Merge the blend terms or take the reciprocal quotient
  assign blend   = acc_r + prod_r[ACC_W-1:0];
  assign merge_v = (cfg.mode == MODE_LOWPASS) ? blend[8 +: SMOOTH_W] :
                                                prod_r[DIV_K +: SMOOTH_W];

  // Scale to millivolts and saturate
  assign mv_full = prod_r[PROD_W-1:MV_SHIFT];
  assign mv_sat  = (mv_full > MVF_W'(MV_MAX)) ? MV_W'(MV_MAX) : mv_full[MV_W-1:0];

  // Select multiplier operands for the current step
  always_comb begin
    unique case (st_r)
      S_STEP1: begin
        mul_a = MUL_A_W'(smooth_rd);
        mul_b = MUL_B_W'(rate_inv);
      end
      S_STEP2: begin
        mul_a = MUL_A_W'(smp_r);
        mul_b = MUL_B_W'(rate_sat);
      end
      S_DIV: begin
        mul_a = MUL_A_W'(sum_r);
        mul_b = DIV_M;
      end
      default: begin
        mul_a = MUL_A_W'(newv_r);
        mul_b = MUL_B_W'(cfg.mv_per_lsb);
      end
    endcase
  end

  // Channel state writes
  assign smooth_we = (st_r == S_MERGE) && ch_ok;
  assign blk_we    = (st_r == S_STEP1) && ch_ok && (cfg.mode == MODE_MEAN);
  assign sum_wd    = blk_done ? '0 : sum_acc;
  assign cnt_wd    = blk_done ? '0 : cnt_rd + CNT_W'(1);

  assign out_load = (st_r == S_OUT) && (!out_valid_r || out_bus.ready);

  // Sequencer next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_acc) st_nxt = S_STEP1;
      end
      S_STEP1: begin
        if (!ch_ok) begin
          st_nxt = S_SCALE;
        end else if (cfg.mode == MODE_LOWPASS) begin
          st_nxt = S_STEP2;
        end else if (blk_done) begin
          st_nxt = S_DIV;
        end else begin
          st_nxt = S_SCALE;
        end
      end
      S_STEP2: st_nxt = S_MERGE;
      S_DIV:   st_nxt = S_MERGE;
      S_MERGE: st_nxt = S_SCALE;
      S_SCALE: st_nxt = S_OUT;
      S_OUT: begin
        if (out_load) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r  <= in_bus.channel;
      smp_r <= in_bus.sample[SMP_W-1:0];
    end
    if (st_r == S_STEP1) begin
      sum_r  <= sum_acc;
      newv_r <= ch_ok ? smooth_rd : '0;
      chg_r  <= 1'b0;
    end
    if (st_r == S_STEP2) begin
      acc_r <= prod_r[ACC_W-1:0];
    end
    if (st_r == S_MERGE) begin
      newv_r <= merge_v;
      chg_r  <= (merge_v != smooth_rd);
    end
  end

  // Hold the result until the request is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch_r     <= ch_r;
      out_smooth_r <= newv_r;
      out_mv_r     <= mv_sat;
      out_chg_r    <= chg_r;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.out_channel = out_ch_r;
  assign out_bus.smoothed    = out_smooth_r;
  assign out_bus.millivolts  = out_mv_r;
  assign out_bus.changed     = out_chg_r;

  // Checks
  `MASF_ASSERT_IMPL(a_cnt_below_depth, (st_r == S_STEP1) && ch_ok, int'(cnt_rd) < DEPTH, "block count reached DEPTH")
  `MASF_ASSERT_IMPL(a_mean_fits, (st_r == S_MERGE) && (cfg.mode == MODE_MEAN), (prod_r >> (DIV_K + SMOOTH_W)) == '0, "mean quotient overflow")
  `MASF_ASSERT_IMPL(a_result_from_out, $rose(out_valid_r), $past(st_r == S_OUT), "result raised outside last step")

endmodule

`default_nettype wire

@@ hdl/masf_cfg_regs.sv @@
// Configuration registers: mode, per-channel rates and millivolt scale.
// Depends on masf_pkg.
`default_nettype none

module masf_cfg_regs
  import masf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  // Write the addressed register; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= MODE_LOWPASS;
      cfg_r.rate[0]    <= RATE0_RST;
      cfg_r.rate[1]    <= RATE_RST;
      cfg_r.rate[2]    <= RATE_RST;
      cfg_r.rate[3]    <= RATE_RST;
      cfg_r.mv_per_lsb <= MVLSB_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILTER_MODE: cfg_r.mode       <= cfg_wdata[0];
        REG_RATE_CH0:    cfg_r.rate[0]    <= cfg_wdata[RATE_W-1:0];
        REG_RATE_CH1:    cfg_r.rate[1]    <= cfg_wdata[RATE_W-1:0];
        REG_RATE_CH2:    cfg_r.rate[2]    <= cfg_wdata[RATE_W-1:0];
        REG_RATE_CH3:    cfg_r.rate[3]    <= cfg_wdata[RATE_W-1:0];
        REG_MV_PER_LSB:  cfg_r.mv_per_lsb <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ hdl/masf_mul.sv @@
// Shared unsigned multiplier with a registered product.
// Used for blend terms, mean reciprocal and millivolt scaling.
`default_nettype none

module masf_mul #(
  parameter int A_W = 12,
  parameter int B_W = 18
) (
  input  wire logic               clk,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output logic      [A_W+B_W-1:0] prod_r
);

  // Register every product
  always_ff @(posedge clk) begin
    prod_r <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

endmodule

`default_nettype wire

@@ hdl/masf_chan_store.sv @@
// Per-channel state: smoothed value, block sum and block count.
// Depends on masf_pkg; all entries clear at reset.
`default_nettype none

module masf_chan_store
  import masf_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int CH_W     = 2,
  parameter int SUM_W    = 14,
  parameter int CNT_W    = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [CH_W-1:0]     idx,
  output logic      [SMOOTH_W-1:0] smooth_rd,
  output logic      [SUM_W-1:0]    sum_rd,
  output logic      [CNT_W-1:0]    cnt_rd,
  input  wire logic                smooth_we,
  input  wire logic [SMOOTH_W-1:0] smooth_wd,
  input  wire logic                blk_we,
  input  wire logic [SUM_W-1:0]    sum_wd,
  input  wire logic [CNT_W-1:0]    cnt_wd
);

  logic [SMOOTH_W-1:0] smooth_r [CHANNELS];
  logic [SUM_W-1:0]    sum_r    [CHANNELS];
  logic [CNT_W-1:0]    cnt_r    [CHANNELS];

  // Read the selected channel
  assign smooth_rd = smooth_r[idx];
  assign sum_rd    = sum_r[idx];
  assign cnt_rd    = cnt_r[idx];

  // Clear at reset, update the selected channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        smooth_r[i] <= '0;
        sum_r[i]    <= '0;
        cnt_r[i]    <= '0;
      end
    end else begin
      if (smooth_we) begin
        smooth_r[idx] <= smooth_wd;
      end
      if (blk_we) begin
        sum_r[idx] <= sum_wd;
        cnt_r[idx] <= cnt_wd;
      end
    end
  end

endmodule

`default_nettype wire
